/* rtl/pfe_pkg.sv */
// Shared types and constants of the postfix expression evaluator.
package pfe_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned STEP_W = $clog2(DATA_W);

  localparam logic [CODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [CODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [CODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [CODE_W-1:0] OP_DIV = 3'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_ILLEGAL   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_OVERFLOW  = 3'd5
  } pfe_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_DIV,
    S_COMMIT,
    S_FINISH
  } pfe_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_tok;
    logic        push;
    logic        set_err;
    pfe_status_e err_val;
    logic        rd_issue;
    logic        div_start;
    logic        res_load;
    logic        commit;
    logic        emit;
  } pfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              is_op;
    logic [CODE_W-1:0] code;
    logic              last;
    logic              err_set;
    logic              full;
    logic              lt2;
    logic              tos_zero;
    logic              div_done;
  } pfe_stat_t;

endpackage

/* rtl/pfe_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module pfe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pfe_pkg::DATA_W-1:0] dividend_i,
  input  logic [pfe_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [pfe_pkg::DATA_W-1:0] quotient_o
);
  import pfe_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (run_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DATA_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/pfe_dp.sv */
// Datapath: token register, value stack with cached top, ALU, divider, result register.
module pfe_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfe_pkg::pfe_cmd_t          cmd_i,
  output pfe_pkg::pfe_stat_t         stat_o,
  input  logic                       is_operator_i,
  input  logic [pfe_pkg::DATA_W-1:0] operand_value_i,
  input  logic [pfe_pkg::CODE_W-1:0] operator_code_i,
  input  logic                       last_token_i,
  output logic                       result_valid_o,
  output logic [pfe_pkg::DATA_W-1:0] result_value_o,
  output logic [2:0]                 status_o
);
  import pfe_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic              tok_op_q;
  logic [DATA_W-1:0] tok_val_q;
  logic [CODE_W-1:0] tok_code_q;
  logic              tok_last_q;

  logic [CW-1:0]     cnt_q, cnt_d;
  pfe_status_e       err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] res_q, res_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  pfe_status_e       out_status_q;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] quotient;
  logic              div_done;

  assign cnt_m1  = cnt_q - CW'(1);
  assign cnt_m2  = cnt_q - CW'(2);
  assign wr_addr = cnt_m1[AW-1:0];
  assign rd_addr = cnt_m2[AW-1:0];

  // Entries below the cached top; tos_q holds entry cnt-1.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (cnt_q != '0)) begin
      mem[wr_addr] <= tos_q;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      tok_op_q   <= is_operator_i;
      tok_val_q  <= operand_value_i;
      tok_code_q <= operator_code_i;
      tok_last_q <= last_token_i;
    end
    tos_q <= tos_d;
    res_q <= res_d;
  end

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    res_d = res_q;
    if (cmd_i.res_load) begin
      unique case (tok_code_q)
        OP_ADD:  res_d = rd_q + tos_q;
        OP_SUB:  res_d = rd_q - tos_q;
        OP_MUL:  res_d = rd_q * tos_q;
        default: res_d = quotient;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    tos_d = tos_q;
    if (cmd_i.push) begin
      tos_d = tok_val_q;
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.commit) begin
      tos_d = res_q;
      cnt_d = cnt_m1;
    end
    if (cmd_i.set_err) begin
      err_d = cmd_i.err_val;
    end
    if (cmd_i.emit) begin
      cnt_d = '0;
      err_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (err_q != ST_OK) begin
        out_value_q  <= '0;
        out_status_q <= err_q;
      end else if (cnt_q == '0) begin
        out_value_q  <= '0;
        out_status_q <= ST_EMPTY;
      end else begin
        out_value_q  <= tos_q;
        out_status_q <= ST_OK;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  assign stat_o.is_op    = tok_op_q;
  assign stat_o.code     = tok_code_q;
  assign stat_o.last     = tok_last_q;
  assign stat_o.err_set  = (err_q != ST_OK);
  assign stat_o.full     = (cnt_q == CW'(STACK_DEPTH));
  assign stat_o.lt2      = (cnt_q < CW'(2));
  assign stat_o.tos_zero = (tos_q == '0);
  assign stat_o.div_done = div_done;

endmodule

/* rtl/pfe_ctrl.sv */
// Controller state machine: sequences one token through the datapath.
module pfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pfe_pkg::pfe_stat_t stat_i,
  output pfe_pkg::pfe_cmd_t  cmd_o
);
  import pfe_pkg::*;

  pfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_val = ST_OK;
    busy    = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_tok = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        priority if (stat_i.err_set) begin
          // sticky error: drop the token
        end else if (!stat_i.is_op) begin
          if (stat_i.full) begin
            cmd_o.set_err = 1'b1;
            cmd_o.err_val = ST_OVERFLOW;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if (stat_i.lt2) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err_val = ST_UNDERFLOW;
        end else if (stat_i.code[2]) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err_val = ST_ILLEGAL;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat_i.code == OP_DIV) begin
          if (stat_i.tos_zero) begin
            cmd_o.set_err = 1'b1;
            cmd_o.err_val = ST_DIVZERO;
            state_d       = S_FINISH;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.res_load = 1'b1;
          state_d        = S_COMMIT;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.emit = stat_i.last;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
// Top level of the postfix expression evaluator: controller plus datapath.
//
// Evaluates a reverse Polish expression one token per command on an unsigned
// 32-bit stack of STACK_DEPTH values. A token transfers at a rising edge with
// start high and busy low; busy then stays high until the token is done.
// Operand tokens pass through decode and finish; add, subtract and multiply
// also pass through fetch and commit, and divide waits between them on the radix-2
// divider that retires one quotient bit per cycle. Only the token marked last
// produces a result: result_valid_o pulses for exactly one cycle, the first
// cycle with busy low again, with result_value_o and status_o beside it. The
// receiver cannot stall, so capture the result on that pulse. The first error
// of an expression is kept and later tokens are dropped until the last token;
// result_value_o is zero whenever status_o is not ok. The stack and error
// clear after each last token. The top of stack lives in a register and the
// rest in a single-port-read memory, so no clearing pass is needed after
// reset.
module postfix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       is_operator_i,
  input  logic [pfe_pkg::DATA_W-1:0] operand_value_i,
  input  logic [pfe_pkg::CODE_W-1:0] operator_code_i,
  input  logic                       last_token_i,
  output logic                       result_valid_o,
  output logic [pfe_pkg::DATA_W-1:0] result_value_o,
  output logic [2:0]                 status_o
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  // Sequence each token: decode, then for an operator fetch the operand below the top, execute and commit, then finish.
  pfe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Hold the stack, error state and result register.
  pfe_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .is_operator_i   (is_operator_i),
    .operand_value_i (operand_value_i),
    .operator_code_i (operator_code_i),
    .last_token_i    (last_token_i),
    .result_valid_o  (result_valid_o),
    .result_value_o  (result_value_o),
    .status_o        (status_o)
  );

endmodule
